// File: src/sqch_pkg.sv
// ----------------------------------------------------------------------------
// sqch_pkg: shared types and constants of the square channel
// Defines the operation codes, the register addresses and the request and
// result records that pass between the top level and the channel core.
// ----------------------------------------------------------------------------
package sqch_pkg;

  typedef enum logic [2:0] {
    OP_WRITE    = 3'd0,
    OP_READ     = 3'd1,
    OP_LENGTH   = 3'd2,
    OP_ENVELOPE = 3'd3,
    OP_SWEEP    = 3'd4,
    OP_PERIOD   = 3'd5
  } op_t;

  localparam logic [15:0] ADDR_SWEEP       = 16'hFF10;
  localparam logic [15:0] ADDR_LENGTH_DUTY = 16'hFF11;
  localparam logic [15:0] ADDR_ENVELOPE    = 16'hFF12;
  localparam logic [15:0] ADDR_PERIOD_LOW  = 16'hFF13;
  localparam logic [15:0] ADDR_PERIOD_HIGH = 16'hFF14;

  localparam logic [10:0] PERIOD_MAX   = 11'h7FF;
  localparam logic [11:0] DIVIDER_WRAP = 12'h800;
  localparam logic [3:0]  VOLUME_MAX   = 4'd15;
  localparam logic [5:0]  LENGTH_MAX   = 6'd63;
  localparam logic [7:0]  MASK_DUTY    = 8'hC0;
  localparam logic [7:0]  MASK_LEN_EN  = 8'h40;
  localparam logic [7:0]  READ_ALL_ONE = 8'hFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        bad_address;
    logic        channel_on;
    logic [3:0]  volume_level;
    logic [10:0] current_period;
    logic [11:0] divider_value;
  } res_t;

endpackage

// File: src/square_channel_with_sweep_control_top.sv
// ----------------------------------------------------------------------------
// square_channel_with_sweep_control_top: pulse channel with sweep and envelope
// Throughput: one request per cycle while out_stall is low; the request
// register feeds the channel core, whose combinational update and result
// logic fill the result register.
// Reset: synchronous, active low; clears both valid flags and all channel
// state (volume comes up at fifteen).
// ----------------------------------------------------------------------------
module square_channel_with_sweep_control_top (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_bad_address,
  output logic        out_channel_on,
  output logic [3:0]  out_volume_level,
  output logic [10:0] out_current_period,
  output logic [11:0] out_divider_value
);

  logic           req_valid_r;
  sqch_pkg::req_t req_r;
  logic           out_valid_r;
  sqch_pkg::res_t res_r;
  sqch_pkg::res_t core_res;
  logic           advance;

  // Move the held request into the result register when that slot is
  // empty or its result is leaving this cycle; the channel state updates
  // on the same edge.
  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  // Hold the request side only while a held request cannot move on.
  assign in_stall = req_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r.op          <= in_op;
      req_r.bus_address <= in_bus_address;
      req_r.write_data  <= in_write_data;
    end
  end

  sqch_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .req   (req_r),
    .res   (core_res)
  );

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = res_r.read_data;
  assign out_bad_address    = res_r.bad_address;
  assign out_channel_on     = res_r.channel_on;
  assign out_volume_level   = res_r.volume_level;
  assign out_current_period = res_r.current_period;
  assign out_divider_value  = res_r.divider_value;

endmodule

// File: src/sqch_core.sv
// ----------------------------------------------------------------------------
// sqch_core: channel registers and per-request update
// Holds the channel state, applies one request when fire is high and shows
// the result that the state after that request gives.
// ----------------------------------------------------------------------------
module sqch_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  sqch_pkg::req_t  req,
  output sqch_pkg::res_t  res
);

  logic [6:0]  sweep_r, sweep_nxt;
  logic [7:0]  length_duty_r, length_duty_nxt;
  logic [7:0]  envelope_r, envelope_nxt;
  logic [7:0]  period_low_r, period_low_nxt;
  logic [6:0]  period_high_r, period_high_nxt;
  logic        enabled_r, enabled_nxt;
  logic        active_r, active_nxt;
  logic [3:0]  volume_r, volume_nxt;
  logic [5:0]  length_cnt_r, length_cnt_nxt;
  logic [2:0]  env_cnt_r, env_cnt_nxt;
  logic [3:0]  sweep_cnt_r, sweep_cnt_nxt;
  logic [11:0] divider_r, divider_nxt;

  logic [10:0] period;
  logic [10:0] step;
  logic [11:0] period_up;
  logic [10:0] period_down;
  logic [2:0]  env_cnt_inc;
  logic [3:0]  sweep_cnt_inc;
  logic [5:0]  length_dec;
  logic [11:0] divider_inc;
  logic [7:0]  read_data;
  logic        bad_address;

  assign period        = {period_high_r[2:0], period_low_r};
  assign step          = period >> sweep_r[2:0];
  assign period_up     = {1'b0, period} + {1'b0, step};
  assign period_down   = period - step;
  assign env_cnt_inc   = env_cnt_r + 3'd1;
  assign sweep_cnt_inc = sweep_cnt_r + 4'd1;
  assign length_dec    = (length_cnt_r != 6'd0) ? length_cnt_r - 6'd1 : length_cnt_r;
  assign divider_inc   = divider_r + 12'd1;

  always_comb begin
    sweep_nxt       = sweep_r;
    length_duty_nxt = length_duty_r;
    envelope_nxt    = envelope_r;
    period_low_nxt  = period_low_r;
    period_high_nxt = period_high_r;
    enabled_nxt     = enabled_r;
    active_nxt      = active_r;
    volume_nxt      = volume_r;
    length_cnt_nxt  = length_cnt_r;
    env_cnt_nxt     = env_cnt_r;
    sweep_cnt_nxt   = sweep_cnt_r;
    divider_nxt     = divider_r;
    read_data       = 8'd0;
    bad_address     = 1'b0;
    case (sqch_pkg::op_t'(req.op))
      sqch_pkg::OP_WRITE: begin
        unique case (req.bus_address)
          sqch_pkg::ADDR_SWEEP:       sweep_nxt = req.write_data[6:0];
          sqch_pkg::ADDR_LENGTH_DUTY: length_duty_nxt = req.write_data;
          sqch_pkg::ADDR_ENVELOPE:    envelope_nxt = req.write_data;
          sqch_pkg::ADDR_PERIOD_LOW:  period_low_nxt = req.write_data;
          sqch_pkg::ADDR_PERIOD_HIGH: begin
            period_high_nxt = req.write_data[6:0];
            // trigger: enable, reload volume, restart the envelope and sweep counters, reload an empty length counter
            if (req.write_data[7]) begin
              enabled_nxt   = 1'b1;
              env_cnt_nxt   = 3'd0;
              volume_nxt    = envelope_r[7:4];
              sweep_cnt_nxt = 4'd0;
              active_nxt    = (envelope_r[2:0] != 3'd0) || (sweep_r[2:0] != 3'd0);
              if (length_cnt_r == 6'd0) begin
                length_cnt_nxt = sqch_pkg::LENGTH_MAX - length_duty_r[5:0];
              end
            end
          end
          default: bad_address = 1'b1;
        endcase
      end
      sqch_pkg::OP_READ: begin
        unique case (req.bus_address)
          sqch_pkg::ADDR_SWEEP:       read_data = {1'b0, sweep_r};
          sqch_pkg::ADDR_LENGTH_DUTY: read_data = length_duty_r & sqch_pkg::MASK_DUTY;
          sqch_pkg::ADDR_ENVELOPE:    read_data = envelope_r;
          sqch_pkg::ADDR_PERIOD_LOW:  read_data = sqch_pkg::READ_ALL_ONE;
          sqch_pkg::ADDR_PERIOD_HIGH: read_data = {1'b0, period_high_r} & sqch_pkg::MASK_LEN_EN;
          default:                    bad_address = 1'b1;
        endcase
      end
      sqch_pkg::OP_LENGTH: begin
        if (enabled_r) begin
          length_cnt_nxt = length_dec;
          if (period_high_r[6] && length_dec == 6'd0) begin
            enabled_nxt = 1'b0;
          end
        end
      end
      sqch_pkg::OP_ENVELOPE: begin
        if (active_r && envelope_r[2:0] != 3'd0) begin
          env_cnt_nxt = env_cnt_inc;
          if (env_cnt_inc >= envelope_r[2:0]) begin
            env_cnt_nxt = 3'd0;
            if (!envelope_r[3]) begin
              if (volume_r != 4'd0) volume_nxt = volume_r - 4'd1;
            end else if (volume_r < sqch_pkg::VOLUME_MAX) begin
              volume_nxt = volume_r + 4'd1;
            end
          end
        end
      end
      sqch_pkg::OP_SWEEP: begin
        if (active_r && sweep_r[6:4] != 3'd0) begin
          sweep_cnt_nxt = sweep_cnt_inc;
          // fire once the count passes the pace
          if (sweep_cnt_inc > {1'b0, sweep_r[6:4]}) begin
            sweep_cnt_nxt = 4'd0;
            if (!sweep_r[3]) begin
              if (period < sqch_pkg::PERIOD_MAX) begin
                if (period_up > {1'b0, sqch_pkg::PERIOD_MAX}) begin
                  enabled_nxt = 1'b0;
                end else begin
                  period_low_nxt  = period_up[7:0];
                  period_high_nxt = {period_high_r[6:3], period_up[10:8]};
                end
              end
            end else if (period != 11'd0) begin
              period_low_nxt  = period_down[7:0];
              period_high_nxt = {period_high_r[6:3], period_down[10:8]};
            end
          end
        end
      end
      sqch_pkg::OP_PERIOD: begin
        divider_nxt = (divider_inc == sqch_pkg::DIVIDER_WRAP) ? {1'b0, period} : divider_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r       <= '0;
      length_duty_r <= '0;
      envelope_r    <= '0;
      period_low_r  <= '0;
      period_high_r <= '0;
      enabled_r     <= 1'b0;
      active_r      <= 1'b0;
      volume_r      <= sqch_pkg::VOLUME_MAX;
      length_cnt_r  <= '0;
      env_cnt_r     <= '0;
      sweep_cnt_r   <= '0;
      divider_r     <= '0;
    end else if (fire) begin
      sweep_r       <= sweep_nxt;
      length_duty_r <= length_duty_nxt;
      envelope_r    <= envelope_nxt;
      period_low_r  <= period_low_nxt;
      period_high_r <= period_high_nxt;
      enabled_r     <= enabled_nxt;
      active_r      <= active_nxt;
      volume_r      <= volume_nxt;
      length_cnt_r  <= length_cnt_nxt;
      env_cnt_r     <= env_cnt_nxt;
      sweep_cnt_r   <= sweep_cnt_nxt;
      divider_r     <= divider_nxt;
    end
  end

  always_comb begin
    res.read_data      = read_data;
    res.bad_address    = bad_address;
    res.channel_on     = enabled_nxt;
    res.volume_level   = volume_nxt;
    res.current_period = {period_high_nxt[2:0], period_low_nxt};
    res.divider_value  = divider_nxt;
  end

endmodule
